// File: hdl/rlbp_pkg.sv
package rlbp_pkg;

	// Width of the result bus: out_bytes, byte_count, packed_length, padded to bytes.
	localparam int OUT_TDATA_W = 56;
	localparam int IN_TDATA_W  = 8;

	localparam logic [7:0]  REPEAT_FLAG = 8'h80;
	localparam logic [15:0] LEN_MAX     = 16'hFFFF;
	localparam logic [2:0]  WORD_BYTES  = 3'd4;

	// Source of the byte produced by the run emitter in a given cycle.
	typedef enum logic [2:0] {
		SRC_NONE  = 3'd0,
		SRC_LHDR  = 3'd1,
		SRC_LDATA = 3'd2,
		SRC_RHDR  = 3'd3,
		SRC_RBYTE = 3'd4
	} gen_src_t;

	typedef struct packed {
		logic     load;
		logic     fin;
		logic     clear;
		logic     flush;
		gen_src_t gen;
	} cmd_t;

	typedef struct packed {
		logic emit_take;
		logic lit_first;
		logic rep_nz;
		logic ld_done;
		logic last;
		logic adv;
		logic flush_need;
		logic flush_ok;
	} sts_t;

endpackage

// File: hdl/rlbp_ram.sv
module rlbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/rlbp_ctrl.sv
module rlbp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  rlbp_pkg::sts_t sts,
	output rlbp_pkg::cmd_t cmd
);

	import rlbp_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_LH    = 7'b0000010,
		ST_LD    = 7'b0000100,
		ST_RH    = 7'b0001000,
		ST_RB    = 7'b0010000,
		ST_FIN   = 7'b0100000,
		ST_FLUSH = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   phase_q;   // set once the end-of-page runs are being sent

	always_comb begin
		cmd      = '0;
		cmd.gen  = SRC_NONE;
		s_tready = 1'b0;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid) begin
					if (sts.emit_take) begin
						state_d = sts.lit_first ? ST_LH : ST_RH;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_LH: begin
				cmd.gen = SRC_LHDR;
				if (sts.adv) begin
					state_d = ST_LD;
				end
			end
			ST_LD: begin
				cmd.gen = SRC_LDATA;
				if (sts.adv && sts.ld_done) begin
					if (sts.rep_nz) begin
						state_d = ST_RH;
					end else begin
						cmd.clear = 1'b1;
						state_d   = phase_q ? ST_FLUSH : ST_FIN;
					end
				end
			end
			ST_RH: begin
				cmd.gen = SRC_RHDR;
				if (sts.adv) begin
					state_d = ST_RB;
				end
			end
			ST_RB: begin
				cmd.gen = SRC_RBYTE;
				if (sts.adv) begin
					cmd.clear = 1'b1;
					state_d   = phase_q ? ST_FLUSH : ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				if (sts.last) begin
					state_d = sts.lit_first ? ST_LH : ST_RH;
				end else if (sts.flush_need) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				cmd.flush = 1'b1;
				if (sts.flush_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				phase_q <= 1'b0;
			end else if (cmd.fin && sts.last) begin
				phase_q <= 1'b1;
			end
		end
	end

endmodule

// File: hdl/rlbp_dp.sv
module rlbp_dp #(
	parameter int RUN_LIMIT = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  rlbp_pkg::cmd_t                       cmd,
	output rlbp_pkg::sts_t                       sts,
	input  logic [rlbp_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic                                 s_tlast,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_data,
	input  logic                                 m_tready,
	output logic                                 m_tvalid,
	output logic [rlbp_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                 m_tlast
);

	import rlbp_pkg::*;

	localparam int            CW     = $clog2(RUN_LIMIT + 1);
	localparam int            AW     = $clog2(RUN_LIMIT);
	localparam logic [CW-1:0] LIM_M1 = CW'(RUN_LIMIT - 1);
	localparam int            PAD_W  = OUT_TDATA_W - 51;

	logic          measure_q;
	logic [7:0]    prev_q;
	logic [7:0]    cur_q;
	logic          last_q;
	logic [CW-1:0] lit_q;
	logic [CW-1:0] rep_q;
	logic [CW-1:0] rd_q;
	logic          in_rep_q;
	logic          started_q;
	logic [15:0]   total_q;
	logic [31:0]   pk_word_q;
	logic [2:0]    pk_cnt_q;

	logic                   m_tvalid_q;
	logic                   m_tlast_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	logic          eq_take;
	logic          out_free;
	logic          adv;
	logic          gen_fire;
	logic          byte_push;
	logic          push_full;
	logic          push_flush;
	logic          flush_need;
	logic          ld_done;
	logic [7:0]    gen_byte;
	logic [7:0]    lit_m1;
	logic [7:0]    rep_m1;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;

	assign eq_take    = (s_tdata == prev_q);
	assign out_free   = !m_tvalid_q || m_tready;
	assign adv        = measure_q || (pk_cnt_q != WORD_BYTES) || out_free;
	assign gen_fire   = (cmd.gen != SRC_NONE) && adv;
	assign byte_push  = gen_fire && !measure_q;
	assign push_full  = byte_push && (pk_cnt_q == WORD_BYTES);
	assign flush_need = measure_q ? last_q : (pk_cnt_q != 3'd0);
	assign push_flush = cmd.flush && flush_need && out_free;
	assign ld_done    = (rd_q == lit_q);

	always_comb begin
		sts            = '0;
		sts.emit_take  = started_q && (in_rep_q ? (!eq_take || (rep_q == LIM_M1))
		                                        : (!eq_take && (lit_q == LIM_M1)));
		sts.lit_first  = !in_rep_q || (lit_q != '0);
		sts.rep_nz     = (rep_q != '0);
		sts.ld_done    = ld_done;
		sts.last       = last_q;
		sts.adv        = adv;
		sts.flush_need = flush_need;
		sts.flush_ok   = !flush_need || out_free;
	end

	// Headers carry the run length minus one in the low seven bits.
	assign lit_m1 = 8'(lit_q) - 8'd1;
	assign rep_m1 = 8'(rep_q) - 8'd1;

	always_comb begin
		case (cmd.gen)
			SRC_LHDR:  gen_byte = {1'b0, lit_m1[6:0]};
			SRC_LDATA: gen_byte = ram_rdata;
			SRC_RHDR:  gen_byte = REPEAT_FLAG | {1'b0, rep_m1[6:0]};
			SRC_RBYTE: gen_byte = prev_q;
			default:   gen_byte = 8'h00;
		endcase
	end

	// Literal store: the held byte goes in when a new unequal byte arrives,
	// the final byte goes in at page end when no repeat is open.
	assign ram_we    = (cmd.load && started_q && !in_rep_q && !eq_take) ||
	                   (cmd.fin && last_q && !in_rep_q);
	assign ram_waddr = lit_q[AW-1:0];
	assign ram_wdata = cmd.load ? prev_q : cur_q;
	assign ram_re    = adv && ((cmd.gen == SRC_LHDR) || ((cmd.gen == SRC_LDATA) && !ld_done));
	assign ram_raddr = (cmd.gen == SRC_LHDR) ? '0 : rd_q[AW-1:0];

	rlbp_ram #(
		.WIDTH(8),
		.DEPTH(RUN_LIMIT)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measure_q <= 1'b0;
			prev_q    <= 8'h00;
			last_q    <= 1'b0;
			lit_q     <= '0;
			rep_q     <= '0;
			rd_q      <= '0;
			in_rep_q  <= 1'b0;
			started_q <= 1'b0;
			total_q   <= 16'h0000;
			pk_cnt_q  <= 3'd0;
		end else begin
			if (cfg_valid) begin
				measure_q <= cfg_data;
			end

			if (cmd.load) begin
				last_q <= s_tlast;
				if (!started_q) begin
					lit_q     <= '0;
					rep_q     <= '0;
					in_rep_q  <= 1'b0;
					started_q <= 1'b1;
				end else if (!in_rep_q) begin
					if (eq_take) begin
						rep_q    <= CW'(1);
						in_rep_q <= 1'b1;
					end else begin
						lit_q <= lit_q + CW'(1);
					end
				end else begin
					rep_q <= rep_q + CW'(1);
				end
			end else if (cmd.fin) begin
				prev_q <= cur_q;
				if (last_q) begin
					started_q <= 1'b0;
					if (!in_rep_q) begin
						lit_q <= lit_q + CW'(1);
					end else begin
						rep_q <= rep_q + CW'(1);
					end
				end
			end else if (cmd.clear) begin
				lit_q    <= '0;
				rep_q    <= '0;
				in_rep_q <= 1'b0;
			end

			// Read pointer runs one entry ahead of the byte being sent.
			if (adv && (cmd.gen == SRC_LHDR)) begin
				rd_q <= CW'(1);
			end else if (adv && (cmd.gen == SRC_LDATA) && !ld_done) begin
				rd_q <= rd_q + CW'(1);
			end

			if (cmd.load && !started_q) begin
				total_q <= 16'h0000;
			end else if (gen_fire && (total_q != LEN_MAX)) begin
				total_q <= total_q + 16'd1;
			end

			if (cmd.load) begin
				pk_cnt_q <= 3'd0;
			end else if (byte_push) begin
				pk_cnt_q <= push_full ? 3'd1 : pk_cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q     <= s_tdata;
			pk_word_q <= 32'h0;
		end else if (byte_push) begin
			if (push_full) begin
				pk_word_q <= {24'h0, gen_byte};
			end else begin
				pk_word_q[{pk_cnt_q[1:0], 3'b000} +: 8] <= gen_byte;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push_full || push_flush) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_full) begin
			m_tdata_q <= {PAD_W'(0), total_q, WORD_BYTES, pk_word_q};
			m_tlast_q <= 1'b0;
		end else if (push_flush) begin
			if (measure_q) begin
				m_tdata_q <= {PAD_W'(0), total_q, 3'd0, 32'h0};
			end else begin
				m_tdata_q <= {PAD_W'(0), total_q, pk_cnt_q, pk_word_q};
			end
			m_tlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

// File: hdl/run_length_byte_packer.sv
// Takes one byte per item; an item that closes no run goes through an accept step and a finish step.
// Sending a literal run emits its header and then its stored bytes, and a repeat run its header and the byte,
// one byte per cycle through the run emitter unless an output stall holds it; a partly filled word is then flushed.
// Output words leave through a single output register; a stall on it holds the emitter.
// Reset (arst_n, asynchronous, active low) clears all control state and measure_only;
// the literal store is not cleared and is only read after it has been written.
module run_length_byte_packer #(
	parameter int RUN_LIMIT = 128
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input bytes.
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [rlbp_pkg::IN_TDATA_W-1:0]  s_tdata,  // [7:0] in_byte
	input  logic                             s_tlast,  // last_byte
	// Packed output words.
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [rlbp_pkg::OUT_TDATA_W-1:0] m_tdata,  // [31:0] out_bytes, [34:32] byte_count,
	                                                    // [50:35] packed_length, [55:51] zero
	output logic                             m_tlast,  // page_end
	// Configuration: measure_only.
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic                             cfg_data
);

	import rlbp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The register is only written while the block is idle, between items.
	assign cfg_ready = s_tready;

	// The controller sequences each item: intake and the run-length update, the
	// literal and repeat runs that the byte closes, the page-end runs, and a final
	// flush of the partly filled output word.
	rlbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the run counters, the literal store, the four-byte
	// packer and the output register.
	rlbp_dp #(
		.RUN_LIMIT(RUN_LIMIT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// Items are worked on one at a time: intake closes right after an accept.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while the previous item is still in work");

	// A word never carries more than four bytes.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[34:32] <= WORD_BYTES))
		else $error("byte_count above four");

	// A result without bytes only appears as the page-end length report.
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[34:32] == 3'd0) |-> m_tlast)
		else $error("empty result before page end");

	// Output data holds while a result waits.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("waiting result changed");

endmodule
